FILE: rtl/core/modexp_pkg.sv
// Package for the modular exponentiation block.
// Holds the field widths, the modular product kinds and the controller/datapath
// command and status structs. It depends on nothing.
package modexp_pkg;

    // Width of every field of the request and result words.
    localparam int FIELD_WIDTH           = 64;
    // Input tdata carries base and exponent side by side.
    localparam int IN_TDATA_WIDTH        = 2 * FIELD_WIDTH;
    // Default arithmetic width; only this many low bits of each value are used.
    localparam int DEFAULT_OPERAND_WIDTH = 64;

    // Which modular product the shared shift-add unit is working on.
    typedef enum logic [1:0] {
        MM_REDUCE   = 2'd0,  // base mod modulus
        MM_SQUARE   = 2'd1,  // acc * acc mod modulus
        MM_MULTIPLY = 2'd2   // acc * base mod modulus
    } t_mm_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;       // capture a request and seed the accumulator
        logic     mm_start;   // clear the product and pick its operands
        logic     mm_step;    // one shift-add step of the product
        logic     commit;     // write the finished product to its target
        logic     exp_shift;  // move to the next exponent bit
        logic     push;       // move the accumulator into the result register
        t_mm_kind mm_kind;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic m_zero;    // configured modulus is zero
        logic mm_last;   // current step is the last one of the product
        logic exp_msb;   // current exponent bit
        logic res_full;  // result register still holds an untaken result
    } t_dp_status;

endpackage

FILE: rtl/core/modexp_datapath.sv
// Datapath of the modular exponentiation block: modulus register, operand
// registers, the interleaved shift-add modular multiplier and the result register.
// Depends on modexp_pkg.
module modexp_datapath #(
    parameter int W = modexp_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0]   i_cfg_wdata,
    input  logic [modexp_pkg::IN_TDATA_WIDTH-1:0] i_req_data,
    input  modexp_pkg::t_dp_cmd                  i_cmd,
    output modexp_pkg::t_dp_status               o_status,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output logic [modexp_pkg::FIELD_WIDTH-1:0]   o_res_data
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;
    localparam int FW = modexp_pkg::FIELD_WIDTH;

    logic [W-1:0]  r_mod;
    logic [W-1:0]  r_base;
    logic [W-1:0]  r_exp;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_opa;
    logic [W-1:0]  r_opb;
    logic [W-1:0]  r_prod;
    logic [CW-1:0] r_cnt;
    logic          r_res_valid;
    logic [FW-1:0] r_res;

    logic [W+1:0]  step_sum;
    logic [W+1:0]  mod_x1;
    logic [W+1:0]  mod_x2;
    logic [W-1:0]  n_prod;
    logic [W-1:0]  addend;

    // One step: prod = (2 * prod + bit * opa) mod m. Since prod and opa are below
    // m, the sum is below 3m and at most two subtractions of m are needed.
    assign addend   = r_opb[W-1] ? r_opa : '0;
    assign step_sum = {1'b0, r_prod, 1'b0} + {2'b00, addend};
    assign mod_x1   = {2'b00, r_mod};
    assign mod_x2   = {1'b0, r_mod, 1'b0};

    always_comb begin
        if (step_sum >= mod_x2) begin
            n_prod = W'(step_sum - mod_x2);
        end else if (step_sum >= mod_x1) begin
            n_prod = W'(step_sum - mod_x1);
        end else begin
            n_prod = step_sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= W'(1);
        end else if (i_cfg_wen) begin
            r_mod <= i_cfg_wdata[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_req_data[W-1:0];
            r_exp  <= i_req_data[FW+W-1:FW];
            // The running value starts at 1 mod m.
            r_acc  <= (r_mod <= W'(1)) ? '0 : W'(1);
        end
        if (i_cmd.mm_start) begin
            r_prod <= '0;
            r_cnt  <= '0;
            unique case (i_cmd.mm_kind)
                modexp_pkg::MM_REDUCE: begin
                    r_opa <= W'(1);
                    r_opb <= r_base;
                end
                modexp_pkg::MM_SQUARE: begin
                    r_opa <= r_acc;
                    r_opb <= r_acc;
                end
                modexp_pkg::MM_MULTIPLY: begin
                    r_opa <= r_base;
                    r_opb <= r_acc;
                end
                default: begin
                    r_opa <= '0;
                    r_opb <= '0;
                end
            endcase
        end
        if (i_cmd.mm_step) begin
            r_prod <= n_prod;
            r_opb  <= r_opb << 1;
            r_cnt  <= r_cnt + CW'(1);
        end
        if (i_cmd.commit) begin
            if (i_cmd.mm_kind == modexp_pkg::MM_REDUCE) begin
                r_base <= r_prod;
            end else begin
                r_acc <= r_prod;
            end
        end
        if (i_cmd.exp_shift) begin
            r_exp <= r_exp << 1;
        end
        if (i_cmd.push) begin
            r_res <= FW'(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_status = '{
        m_zero:   (r_mod == '0),
        mm_last:  (r_cnt == CW'(W - 1)),
        exp_msb:  r_exp[W-1],
        res_full: r_res_valid
    };

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res;

    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (r_prod < r_mod))
        else $error("modular product not below the modulus at commit");

    a_push_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !r_res_valid)
        else $error("result pushed over an untaken result");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mm_start |=> (r_prod == '0) && (r_cnt == '0))
        else $error("product start did not clear the partial product");

endmodule

FILE: rtl/core/modexp_ctrl.sv
// Controller of the modular exponentiation block: sequences the reduction of
// the base and the square and multiply products over the exponent bits.
// Depends on modexp_pkg.
module modexp_ctrl #(
    parameter int W = modexp_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    input  modexp_pkg::t_dp_status i_status,
    output modexp_pkg::t_dp_cmd    o_cmd
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_START  = 5'b00010,
        S_RUN    = 5'b00100,
        S_COMMIT = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    modexp_pkg::t_mm_kind r_kind, n_kind;
    logic [CW-1:0]        r_bit_cnt, n_bit_cnt;

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_bit_cnt = r_bit_cnt;
        o_cmd     = '0;
        o_cmd.mm_kind = r_kind;
        o_req_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit_cnt  = '0;
                    n_kind     = modexp_pkg::MM_REDUCE;
                    // A zero modulus gives a zero result without any product.
                    n_state    = i_status.m_zero ? S_DONE : S_START;
                end
            end
            S_START: begin
                o_cmd.mm_start = 1'b1;
                n_state        = S_RUN;
            end
            S_RUN: begin
                o_cmd.mm_step = 1'b1;
                if (i_status.mm_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (r_kind == modexp_pkg::MM_REDUCE) begin
                    n_kind  = modexp_pkg::MM_SQUARE;
                    n_state = S_START;
                end else if (r_kind == modexp_pkg::MM_SQUARE && i_status.exp_msb) begin
                    n_kind  = modexp_pkg::MM_MULTIPLY;
                    n_state = S_START;
                end else begin
                    o_cmd.exp_shift = 1'b1;
                    if (r_bit_cnt == CW'(W - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_bit_cnt = r_bit_cnt + CW'(1);
                        n_kind    = modexp_pkg::MM_SQUARE;
                        n_state   = S_START;
                    end
                end
            end
            S_DONE: begin
                if (!i_status.res_full) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_kind    <= modexp_pkg::MM_REDUCE;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_kind    <= n_kind;
            r_bit_cnt <= n_bit_cnt;
        end
    end

    a_mult_needs_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_kind == modexp_pkg::MM_SQUARE && !i_status.exp_msb)
        |=> (r_kind != modexp_pkg::MM_MULTIPLY))
        else $error("multiply scheduled for a clear exponent bit");

    a_step_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mm_start |=> o_cmd.mm_step)
        else $error("product started without stepping");

    a_reduce_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && !i_status.m_zero) |=> (r_kind == modexp_pkg::MM_REDUCE))
        else $error("base reduction not first after a request");

endmodule

FILE: rtl/core/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: result = base^exponent mod modulus.
// Instantiates modexp_ctrl and modexp_datapath; depends on modexp_pkg.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: base, exponent
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: result
// cfg       in   i_cfg_wen                      i_cfg_wdata: modulus
//
// One request at a time is processed. Each modular product takes OPERAND_WIDTH
// shift-add steps plus a start and a commit step in the shared multiplier.
// A request needs 1 + OPERAND_WIDTH + popcount(exponent) products from acceptance
// to result; with a zero modulus the result is ready without any product.
// Reset is synchronous and active low and sets the modulus to 1.
// The result register holds a finished result while the next request is taken;
// a stalled result holds the controller only when the following one is done.
module modular_exponentiation_top #(
    parameter int OPERAND_WIDTH = modexp_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration: the modulus, written whenever i_cfg_wen is high.
    input  logic                                  i_cfg_wen,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0]    i_cfg_wdata,
    // Request channel.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0 up: base [63:0], exponent [127:64].
    input  logic [modexp_pkg::IN_TDATA_WIDTH-1:0] s_axis_tdata,
    // Result channel.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0 up: result [63:0].
    output logic [modexp_pkg::FIELD_WIDTH-1:0]    m_axis_tdata
);

    // Command and status buses between the controller and the datapath.
    modexp_pkg::t_dp_cmd    cmd;
    modexp_pkg::t_dp_status status;

    // The controller owns the request handshake and the product sequence.
    modexp_ctrl #(
        .W (OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the modulus, the operands, the shift-add multiplier
    // and the result register that drives the result channel.
    modexp_datapath #(
        .W (OPERAND_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_data  (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_data  (m_axis_tdata)
    );

endmodule
